// ===== rtl/csf_pkg.sv =====
// Shared types and constants for the container format sniffer.
package csf_pkg;

   // Default sizes
   localparam int LOOKAHEAD_DEFAULT = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Bytes the marker checker looks at: four code bytes plus twenty followers
   localparam int JUDGE_BYTES = 24;
   localparam int CODE_BYTES = 4;

   // Byte counter
   localparam int SEEN_W = 25;
   localparam logic [SEEN_W-1:0] SEEN_MAX = 25'h1FF_FFFF;

   // Scan limit register
   localparam int LIMIT_W = 24;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd51200;

   // Start markers
   localparam logic [31:0] MARK_SVAC_A = 32'h0000_01EA;
   localparam logic [31:0] MARK_SVAC_B = 32'h0000_01ED;
   localparam logic [31:0] MARK_SVAC_C = 32'h0000_01EC;
   localparam logic [31:0] MARK_XM = 32'h0000_01FC;
   localparam logic [31:0] MARK_NEW_A = 32'h0000_01FD;
   localparam logic [31:0] MARK_NEW_B = 32'h0000_01FE;
   localparam logic [31:0] MARK_AUDIO = 32'h0000_01F0;
   localparam logic [31:0] MARK_PS = 32'h0000_01BA;
   localparam logic [31:0] MARK_RIFF = 32'h5249_4646;
   localparam logic [31:0] MARK_STD = 32'h4448_4156;
   localparam logic [31:0] TAG_AVI = 32'h4156_4920;

   // Checksum seed: the four code bytes of the std marker, mod 256
   localparam logic [7:0] STD_SEED = 8'h23;

   // Follower bytes needed per marker kind
   localparam int NEED_SVAC = 20;
   localparam int NEED_XM = 12;
   localparam int NEED_RIFF = 9;
   localparam int NEED_STD = 20;

   // Range limits
   localparam logic [15:0] SVAC_DIM_MIN = 16'd120;
   localparam logic [15:0] SVAC_DIM_MAX = 16'd4096;
   localparam logic [7:0] SVAC_ENC_MAX = 8'd5;
   localparam logic [7:0] SVAC_RATE_MAX = 8'd100;
   localparam logic [7:0] XM_DIM_MIN = 8'd15;    // 15 * 8 = 120
   localparam logic [7:0] XM_DIM_MAX = 8'd240;   // 240 * 8 = 1920
   localparam logic [7:0] XM_RATE_MASK = 8'h1F;
   localparam logic [7:0] XM_RATE_MAX = 8'd30;
   localparam logic [7:0] NEW_RATE_MAX = 8'd100;

   // Sticky flag bit positions
   localparam int FLAG_W = 7;
   localparam int FLAG_AVI = 0;
   localparam int FLAG_STD = 1;
   localparam int FLAG_NEW = 2;
   localparam int FLAG_XM = 3;
   localparam int FLAG_SVAC = 4;
   localparam int FLAG_PS = 5;
   localparam int FLAG_AUDIO = 6;

   // Format codes
   localparam logic [2:0] FMT_NONE = 3'd0;
   localparam logic [2:0] FMT_AVI = 3'd1;
   localparam logic [2:0] FMT_STD = 3'd2;
   localparam logic [2:0] FMT_NEW = 3'd3;
   localparam logic [2:0] FMT_XM = 3'd4;
   localparam logic [2:0] FMT_SVAC = 3'd5;
   localparam logic [2:0] FMT_PS = 3'd6;
   localparam logic [2:0] FMT_AUDIO = 3'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [2:0] format_code;
      logic       stopped_early;
   } rsp_item_type;

endpackage

// ===== rtl/csf_if.sv =====
// Channel interfaces for the container format sniffer.
interface csf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;
   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface csf_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] format_code;
   logic       stopped_early;
   modport source (output valid, output format_code, output stopped_early, input ready);
   modport sink (input valid, input format_code, input stopped_early, output ready);
endinterface

interface csf_csr_if;
   logic        valid;
   logic        ready;
   logic [23:0] write_data;
   modport source (output valid, output write_data, input ready);
   modport sink (input valid, input write_data, output ready);
endinterface

// ===== rtl/csf_queue.sv =====
// Input queue between the byte intake and the scan engine.
module csf_queue import csf_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  req_item_type in_item,
   output logic         out_valid,
   input  logic         out_ready,
   output req_item_type out_item
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   req_item_type    mem_ff [DEPTH];
   logic [IW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            push, pop;

   assign in_ready  = (count_ff != CW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/csf_judge.sv =====
// Marker checker: classifies the marker at the head of the byte window.
module csf_judge import csf_pkg::*; #(
   parameter int LOOKAHEAD_BYTES = LOOKAHEAD_DEFAULT
) (
   input  logic [JUDGE_BYTES-1:0][7:0]          win,
   input  logic [$clog2(LOOKAHEAD_BYTES+1)-1:0] avail,
   output logic [FLAG_W-1:0]                    hit
);

   localparam int AW = $clog2(LOOKAHEAD_BYTES + 1);

   logic [31:0] code;
   logic [7:0]  q [JUDGE_BYTES-CODE_BYTES];
   logic [15:0] svac_w, svac_h;
   logic [7:0]  xm_rate;
   logic [31:0] tag;
   logic        svac_ok, xm_dims_ok;
   logic [7:0]  t0 [20];
   logic [7:0]  t1 [10];
   logic [7:0]  t2 [5];
   logic [7:0]  t3 [3];
   logic [7:0]  t4 [2];
   logic [7:0]  csum;

   // Unpack code and follower bytes
   always_comb begin
      code = {win[0], win[1], win[2], win[3]};
      for (int i = 0; i < JUDGE_BYTES - CODE_BYTES; i++) begin
         q[i] = win[CODE_BYTES + i];
      end
   end

   // Range checks
   always_comb begin
      svac_w  = {q[5], q[4]};
      svac_h  = {q[7], q[6]};
      xm_rate = q[1] & XM_RATE_MASK;
      tag     = {q[4], q[5], q[6], q[7]};
      svac_ok = (q[0] >= 8'd1) && (q[0] <= SVAC_ENC_MAX)
             && (svac_w >= SVAC_DIM_MIN) && (svac_w <= SVAC_DIM_MAX)
             && (svac_h >= SVAC_DIM_MIN) && (svac_h <= SVAC_DIM_MAX)
             && (q[2] >= 8'd1) && (q[2] <= SVAC_RATE_MAX);
      xm_dims_ok = (q[2] >= XM_DIM_MIN) && (q[2] <= XM_DIM_MAX)
                && (q[3] >= XM_DIM_MIN) && (q[3] <= XM_DIM_MAX);
   end

   // Sum the std header as a balanced tree
   always_comb begin
      for (int i = 0; i < 19; i++) begin
         t0[i] = q[i];
      end
      t0[19] = STD_SEED;
      for (int i = 0; i < 10; i++) begin
         t1[i] = t0[2*i] + t0[2*i+1];
      end
      for (int i = 0; i < 5; i++) begin
         t2[i] = t1[2*i] + t1[2*i+1];
      end
      t3[0] = t2[0] + t2[1];
      t3[1] = t2[2] + t2[3];
      t3[2] = t2[4];
      t4[0] = t3[0] + t3[1];
      t4[1] = t3[2];
      csum  = t4[0] + t4[1];
   end

   // Classify the marker
   always_comb begin
      hit = '0;
      if (code == MARK_SVAC_A) begin
         hit[FLAG_SVAC] = (avail >= AW'(NEED_SVAC));
      end else if (code == MARK_SVAC_B || code == MARK_SVAC_C) begin
         hit[FLAG_SVAC] = (avail >= AW'(NEED_SVAC)) && svac_ok;
      end else if (code == MARK_XM) begin
         hit[FLAG_XM] = (avail >= AW'(NEED_XM)) && xm_dims_ok
                     && (xm_rate >= 8'd1) && (xm_rate <= XM_RATE_MAX);
      end else if (code == MARK_NEW_A || code == MARK_NEW_B) begin
         hit[FLAG_NEW] = (avail >= AW'(NEED_XM)) && xm_dims_ok
                      && (xm_rate >= 8'd1) && (xm_rate <= NEW_RATE_MAX);
      end else if (code == MARK_AUDIO) begin
         hit[FLAG_AUDIO] = 1'b1;
      end else if (code == MARK_PS) begin
         hit[FLAG_PS] = 1'b1;
      end else if (code == MARK_RIFF) begin
         hit[FLAG_AVI] = (avail >= AW'(NEED_RIFF)) && (tag == TAG_AVI);
      end else if (code == MARK_STD) begin
         hit[FLAG_STD] = (avail >= AW'(NEED_STD)) && (csum == q[19]);
      end
   end

endmodule

// ===== rtl/csf_back.sv =====
// Scan engine: byte window, marker judging, end-of-buffer flush and result register.
module csf_back import csf_pkg::*; #(
   parameter int LOOKAHEAD_BYTES = LOOKAHEAD_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  req_item_type       pop_item,
   input  logic [LIMIT_W-1:0] scan_limit,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_item_type       rsp_item
);

   localparam int WIN = LOOKAHEAD_BYTES + CODE_BYTES;
   localparam int AW  = $clog2(LOOKAHEAD_BYTES + 1);

   typedef enum logic [1:0] {ST_SCAN, ST_FLUSH, ST_EMIT} state_type;

   state_type                  state_ff, state_in;
   logic [7:0]                 win_ff [WIN];
   logic [7:0]                 win_in [WIN];
   logic [7:0]                 win_sh [WIN];
   logic [SEEN_W-1:0]          seen_ff, seen_in, seen_inc, seen_cur;
   logic [FLAG_W-1:0]          flags_ff, flags_in;
   logic                       stopped_ff, stopped_in;
   logic [AW-1:0]              cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_item_type               rsp_item_ff, rsp_item_in;
   logic [JUDGE_BYTES-1:0][7:0] judge_win;
   logic [AW-1:0]              avail;
   logic [FLAG_W-1:0]          hit;
   logic [SEEN_W-1:0]          pos;
   logic                       judge_en;
   logic [7:0]                 shift_byte;
   logic                       pop;
   logic [2:0]                 code_sel;

   assign pop_ready = (state_ff == ST_SCAN);
   assign pop       = pop_valid && pop_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Shift the window by one, filling with the new byte or with ones during flush
   assign shift_byte = (state_ff == ST_FLUSH) ? 8'hFF : pop_item.data_byte;
   always_comb begin
      for (int i = 0; i < WIN - 1; i++) begin
         win_sh[i] = win_ff[i+1];
      end
      win_sh[WIN-1] = shift_byte;
      for (int i = 0; i < JUDGE_BYTES; i++) begin
         judge_win[i] = win_sh[i];
      end
   end

   // Followers available and marker position
   assign seen_inc = (seen_ff == SEEN_MAX) ? seen_ff : seen_ff + 1'b1;
   assign seen_cur = (state_ff == ST_FLUSH) ? seen_ff : seen_inc;
   assign avail    = (state_ff == ST_FLUSH) ? (AW'(LOOKAHEAD_BYTES - 1) - cnt_ff)
                                            : AW'(LOOKAHEAD_BYTES);
   assign pos      = seen_cur - SEEN_W'(avail);
   assign judge_en = !stopped_ff && ((state_ff == ST_SCAN && pop) || state_ff == ST_FLUSH);

   csf_judge #(
      .LOOKAHEAD_BYTES(LOOKAHEAD_BYTES)
   ) u_judge (
      .win  (judge_win),
      .avail(avail),
      .hit  (hit)
   );

   // Pick the format code by priority
   always_comb begin
      if (flags_ff[FLAG_AVI]) begin
         code_sel = FMT_AVI;
      end else if (flags_ff[FLAG_STD]) begin
         code_sel = FMT_STD;
      end else if (flags_ff[FLAG_NEW]) begin
         code_sel = FMT_NEW;
      end else if (flags_ff[FLAG_XM]) begin
         code_sel = FMT_XM;
      end else if (flags_ff[FLAG_SVAC]) begin
         code_sel = FMT_SVAC;
      end else if (flags_ff[FLAG_PS]) begin
         code_sel = FMT_PS;
      end else if (flags_ff[FLAG_AUDIO]) begin
         code_sel = FMT_AUDIO;
      end else begin
         code_sel = FMT_NONE;
      end
   end

   // Sequence scan, flush and emit
   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      seen_in      = seen_ff;
      flags_in     = flags_ff;
      stopped_in   = stopped_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;

      if (judge_en) begin
         win_in   = win_sh;
         flags_in = flags_ff | hit;
         if ((hit != '0) && (hit[FLAG_AVI] || (pos > {1'b0, scan_limit}))) begin
            stopped_in = 1'b1;
         end
      end

      case (state_ff)
         ST_SCAN: begin
            if (pop) begin
               if (!stopped_ff) begin
                  seen_in = seen_inc;
               end
               if (pop_item.last_byte) begin
                  cnt_in   = '0;
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == AW'(LOOKAHEAD_BYTES - 1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in              = 1'b1;
               rsp_item_in.format_code   = code_sel;
               rsp_item_in.stopped_early = stopped_ff;
               for (int i = 0; i < WIN; i++) begin
                  win_in[i] = 8'hFF;
               end
               seen_in    = '0;
               flags_in   = '0;
               stopped_in = 1'b0;
               state_in   = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_SCAN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SCAN;
         for (int i = 0; i < WIN; i++) begin
            win_ff[i] <= 8'hFF;
         end
         seen_ff      <= '0;
         flags_ff     <= '0;
         stopped_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_ff       <= win_in;
         seen_ff      <= seen_in;
         flags_ff     <= flags_in;
         stopped_ff   <= stopped_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_item_ff <= rsp_item_in;
   end

endmodule

// ===== rtl/container_format_sniffer.sv =====
// Top level of the container format sniffer.
// Throughput: one byte per cycle while scanning; the scan engine judges one marker per cycle until it stops early.
// After the last byte of a buffer the engine flushes the pending markers, then emits the result
// once the result register is free or being read; no new bytes are taken meanwhile.
// Reset: synchronous; scan_limit returns to 51200, queue empties, window fills with ones.
// No clearing pass is needed after reset.
module container_format_sniffer import csf_pkg::*; #(
   parameter int LOOKAHEAD_BYTES = LOOKAHEAD_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input logic      clock,
   input logic      reset,
   csf_req_if.sink  req_chan,
   csf_rsp_if.source rsp_chan,
   csf_csr_if.sink  csr_chan
);

   logic [LIMIT_W-1:0] scan_limit_ff, scan_limit_in;
   req_item_type       req_item;
   req_item_type       q_item;
   logic               q_valid, q_ready;
   rsp_item_type       rsp_item;

   // Hold the scan limit register
   assign csr_chan.ready = 1'b1;
   assign scan_limit_in  = (csr_chan.valid) ? csr_chan.write_data : scan_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_limit_ff <= LIMIT_RESET;
      end else begin
         scan_limit_ff <= scan_limit_in;
      end
   end

   assign req_item.data_byte = req_chan.data_byte;
   assign req_item.last_byte = req_chan.last_byte;

   csf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .in_item  (req_item),
      .out_valid(q_valid),
      .out_ready(q_ready),
      .out_item (q_item)
   );

   csf_back #(
      .LOOKAHEAD_BYTES(LOOKAHEAD_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (q_valid),
      .pop_ready (q_ready),
      .pop_item  (q_item),
      .scan_limit(scan_limit_ff),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_chan.format_code   = rsp_item.format_code;
   assign rsp_chan.stopped_early = rsp_item.stopped_early;

endmodule

// ===== test/tb.sv =====
// Testbench for the container format sniffer: marker scan prediction and result checking.
`timescale 1ns / 100ps

module tb;
   import csf_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   csf_req_if req_chan ();
   csf_rsp_if rsp_chan ();
   csf_csr_if csr_chan ();

   container_format_sniffer u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   localparam int WIN = 24;
   localparam int LOOK = 20;

   // Predictor state
   logic [7:0]        pred_win [WIN];
   logic [SEEN_W-1:0] pred_seen;
   logic [6:0]        pred_flags;
   logic              pred_stop;
   logic [LIMIT_W-1:0] pred_limit;

   req_item_type byte_queue [$];
   rsp_item_type format_queue [$];
   int err_count = 0;
   int buffers_done = 0;
   int stopped_seen = 0;
   bit quiet_tail = 0;
   bit stim_done = 0;

   task automatic clear_scan();
      for (int i = 0; i < WIN; i++) pred_win[i] = 8'hFF;
      pred_seen = '0;
      pred_flags = '0;
      pred_stop = 1'b0;
   endtask

   // Judge the marker with f bytes after it in the window
   task automatic judge_marker(input int f);
      int base;
      logic [31:0] code, tag;
      logic [7:0] q [20];
      logic [15:0] w, h;
      logic [7:0] r, sum;
      logic [6:0] hit;
      logic [SEEN_W-1:0] pos;
      base = WIN - 4 - f;
      code = {pred_win[base], pred_win[base+1], pred_win[base+2], pred_win[base+3]};
      for (int i = 0; i < 20; i++) q[i] = (base + 4 + i < WIN) ? pred_win[base+4+i] : 8'h00;
      pos = SEEN_W'(pred_seen - SEEN_W'(f));
      hit = '0;
      if (code == MARK_SVAC_A) begin
         if (f >= 20) hit[FLAG_SVAC] = 1'b1;
      end else if (code == MARK_SVAC_B || code == MARK_SVAC_C) begin
         if (f >= 20) begin
            w = {q[5], q[4]};
            h = {q[7], q[6]};
            r = q[2];
            if (q[0] >= 1 && q[0] <= 5 && w >= 120 && w <= 4096 && h >= 120 && h <= 4096
                && r >= 1 && r <= 100) hit[FLAG_SVAC] = 1'b1;
         end
      end else if (code == MARK_XM || code == MARK_NEW_A || code == MARK_NEW_B) begin
         if (f >= 12) begin
            r = q[1] & 8'h1F;
            if (q[2] >= 15 && q[2] <= 240 && q[3] >= 15 && q[3] <= 240 && r >= 1
                && r <= ((code == MARK_XM) ? 30 : 100)) begin
               if (code == MARK_XM) hit[FLAG_XM] = 1'b1;
               else hit[FLAG_NEW] = 1'b1;
            end
         end
      end else if (code == MARK_AUDIO) begin
         hit[FLAG_AUDIO] = 1'b1;
      end else if (code == MARK_PS) begin
         hit[FLAG_PS] = 1'b1;
      end else if (code == MARK_RIFF) begin
         if (f >= 9) begin
            tag = {q[4], q[5], q[6], q[7]};
            if (tag == TAG_AVI) hit[FLAG_AVI] = 1'b1;
         end
      end else if (code == MARK_STD) begin
         if (f >= 20) begin
            sum = STD_SEED;
            for (int i = 0; i < 19; i++) sum = sum + q[i];
            if (sum == q[19]) hit[FLAG_STD] = 1'b1;
         end
      end
      if (hit != 0) begin
         pred_flags = pred_flags | hit;
         if (hit[FLAG_AVI] || pos > {1'b0, pred_limit}) pred_stop = 1'b1;
      end
   endtask

   // Advance the predictor by one accepted byte
   task automatic predict_byte(input req_item_type it);
      rsp_item_type res;
      if (!pred_stop) begin
         for (int i = 0; i < WIN - 1; i++) pred_win[i] = pred_win[i+1];
         pred_win[WIN-1] = it.data_byte;
         if (pred_seen < SEEN_MAX) pred_seen = pred_seen + 1'b1;
         if (pred_seen >= LOOK + 1) judge_marker(LOOK);
      end
      if (it.last_byte) begin
         for (int f = LOOK; f > 0; f--) begin
            if (pred_stop) break;
            if (pred_seen >= f) judge_marker(f - 1);
         end
         if (pred_flags[FLAG_AVI]) res.format_code = FMT_AVI;
         else if (pred_flags[FLAG_STD]) res.format_code = FMT_STD;
         else if (pred_flags[FLAG_NEW]) res.format_code = FMT_NEW;
         else if (pred_flags[FLAG_XM]) res.format_code = FMT_XM;
         else if (pred_flags[FLAG_SVAC]) res.format_code = FMT_SVAC;
         else if (pred_flags[FLAG_PS]) res.format_code = FMT_PS;
         else if (pred_flags[FLAG_AUDIO]) res.format_code = FMT_AUDIO;
         else res.format_code = FMT_NONE;
         res.stopped_early = pred_stop;
         format_queue.push_back(res);
         clear_scan();
      end
   endtask

   // Note whether the presented byte was taken at the last rising edge
   bit req_took = 1'b0;
   always @(posedge clock) begin
      req_took <= req_chan.valid && req_chan.ready;
   end

   // Driver: present queued bytes at the falling edge, with random idle bursts
   int req_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_took) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_chan.valid <= 1'b0;
         end else if (byte_queue.size() > 0 && !quiet_tail && $urandom_range(0, 15) == 0) begin
            req_gap <= $urandom_range(0, 18);
            req_chan.valid <= 1'b0;
         end else if (byte_queue.size() > 0) begin
            req_chan.valid <= 1'b1;
            req_chan.data_byte <= byte_queue[0].data_byte;
            req_chan.last_byte <= byte_queue[0].last_byte;
            void'(byte_queue.pop_front());
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side back-pressure
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
         rsp_gap <= $urandom_range(0, 18);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Monitor: predict on accepted bytes, check accepted results
   int idle_cycles = 0;
   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type got;
      bit moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            got.data_byte = req_chan.data_byte;
            got.last_byte = req_chan.last_byte;
            predict_byte(got);
            moved = 1'b1;
         end
         if (csr_chan.valid && csr_chan.ready) moved = 1'b1;
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (format_queue.size() == 0) begin
               $error("unexpected transaction: format_code %0d", rsp_chan.format_code);
               err_count++;
            end else begin
               want = format_queue.pop_front();
               buffers_done++;
               if (want.stopped_early) stopped_seen++;
               if (rsp_chan.format_code !== want.format_code) begin
                  $error("format_code expected %0d actual %0d", want.format_code,
                         rsp_chan.format_code);
                  err_count++;
               end
               if (rsp_chan.stopped_early !== want.stopped_early) begin
                  $error("stopped_early expected %0d actual %0d", want.stopped_early,
                         rsp_chan.stopped_early);
                  err_count++;
               end
            end
         end
         idle_cycles <= moved ? 0 : idle_cycles + 1;
         if (idle_cycles > 5000) begin
            $display("watchdog expired");
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Buffer builders
   task automatic push_byte(input logic [7:0] b, input bit last = 0);
      req_item_type it;
      it.data_byte = b;
      it.last_byte = last;
      byte_queue.push_back(it);
   endtask

   task automatic push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) push_byte(w[i*8 +: 8]);
   endtask

   // Append one marker with random content; good makes the checked fields valid
   task automatic push_marker(input int kind, input bit good);
      logic [7:0] q [20];
      logic [7:0] sum;
      logic [15:0] w, h;
      for (int i = 0; i < 20; i++) q[i] = 8'($urandom);
      case (kind)
         0: begin
            push_word(MARK_SVAC_A);
         end
         1: begin
            push_word($urandom_range(0, 1) ? MARK_SVAC_B : MARK_SVAC_C);
            if (good) begin
               q[0] = 8'($urandom_range(1, 5));
               w = $urandom_range(0, 3) == 0 ? 16'd4096 : 16'($urandom_range(120, 4096));
               h = $urandom_range(0, 3) == 0 ? 16'd120 : 16'($urandom_range(120, 4096));
               {q[5], q[4]} = w;
               {q[7], q[6]} = h;
               q[2] = 8'($urandom_range(1, 100));
            end
         end
         2, 3: begin
            push_word(kind == 2 ? MARK_XM :
                      ($urandom_range(0, 1) ? MARK_NEW_A : MARK_NEW_B));
            if (good) begin
               q[1] = {3'($urandom_range(0, 7)), 5'(0)} |
                      8'($urandom_range(1, kind == 2 ? 30 : 31));
               q[2] = 8'($urandom_range(15, 240));
               q[3] = 8'($urandom_range(15, 240));
            end
         end
         4: push_word(MARK_AUDIO);
         5: push_word(MARK_PS);
         6: begin
            push_word(MARK_RIFF);
            if (good) {q[4], q[5], q[6], q[7]} = TAG_AVI;
         end
         default: begin
            push_word(MARK_STD);
            sum = STD_SEED;
            for (int i = 0; i < 19; i++) sum = sum + q[i];
            if (good) q[19] = sum;
         end
      endcase
      for (int i = 0; i < 20; i++) push_byte(q[i]);
   endtask

   // Random buffer: markers between filler, sometimes cut short at the end
   task automatic push_buffer(output int n);
      int parts;
      n = byte_queue.size();
      parts = $urandom_range(0, 4);
      for (int p = 0; p < parts; p++) begin
         repeat ($urandom_range(0, 6))
            push_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom));
         if ($urandom_range(0, 5) != 0) push_marker($urandom_range(0, 7), $urandom_range(0, 3) != 0);
      end
      // Trim some buffers so the tail markers are short
      if ($urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 15))
            if (byte_queue.size() > n) void'(byte_queue.pop_back());
      end
      if (byte_queue.size() == n) push_byte(8'($urandom));
      byte_queue[byte_queue.size()-1].last_byte = 1'b1;
      n = byte_queue.size() - n;
   endtask

   // Write the limit while idle
   task automatic write_limit(input logic [LIMIT_W-1:0] v);
      while (byte_queue.size() > 0 || format_queue.size() > 0 || req_chan.valid)
         @(posedge clock);
      repeat (LOOK + 6) @(posedge clock);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.write_data <= v;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      pred_limit = v;
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   initial begin
      int n, total;
      logic [LIMIT_W-1:0] limits [4];
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.last_byte = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_chan.valid = 1'b0;
      csr_chan.write_data = '0;
      pred_limit = LIMIT_RESET;
      clear_scan();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: single bytes, each marker kind good, short markers
      push_byte(8'h00, 1);
      push_byte(8'hFF, 1);
      for (int k = 0; k < 8; k++) begin
         push_marker(k, 1);
         push_byte(8'hAA, 1);
      end
      push_word(MARK_STD);
      push_byte(8'h12, 1);
      push_word(MARK_AUDIO);
      push_byte(8'h00, 1);
      push_marker(6, 1);
      push_marker(7, 1);
      push_byte(8'h00, 1);

      // Random phases over several limits, extremes included
      limits[0] = 24'd0;
      limits[1] = 24'd30;
      limits[2] = 24'hFFFFFF;
      limits[3] = LIMIT_W'($urandom_range(1, 80));
      total = byte_queue.size();
      for (int ph = 0; ph < 4; ph++) begin
         write_limit(limits[ph]);
         for (int b = 0; b < 6 && total < 1850; b++) begin
            push_buffer(n);
            total += n;
         end
         if (ph == 3) begin
            while (total < 1850) begin
               push_buffer(n);
               total += n;
               if (total > 1650) quiet_tail = 1;
            end
         end
         if (ph < 3) begin
            repeat (4) begin
               push_buffer(n);
               total += n;
            end
         end
      end
      write_limit(LIMIT_RESET);
      push_marker(4, 1);
      push_byte(8'h55, 1);

      while (byte_queue.size() > 0 || format_queue.size() > 0) @(posedge clock);
      repeat (LOOK + 10) @(posedge clock);
      $display("covered %0d buffers over %0d bytes, %0d stopped early, limits 0 to max",
               buffers_done, total, stopped_seen);
      if (err_count == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/csf_pkg.sv
rtl/csf_if.sv
rtl/csf_queue.sv
rtl/csf_judge.sv
rtl/csf_back.sv
rtl/container_format_sniffer.sv
test/tb.sv
